// ----- hw/rtl/bdeq_pkg.sv -----
// Package: shared types, codes and constants of the bounded double-ended queue.
`timescale 1ns / 1ps

package bdeq_pkg;

  // Word and register widths fixed by the interface
  localparam int WORD_W        = 32;
  localparam int FUNC_W        = 3;
  localparam int CAP_W         = 11;
  localparam int DEPTH_DEFAULT = 1024;

  localparam logic [CAP_W-1:0]         CAP_RESET  = 11'd1024;
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

  // Operation codes carried in the func field
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_QUERY      = 3'd4
  } func_t;

  // Input transaction
  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [WORD_W-1:0]  value;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic                      ok;
    logic                      is_empty;
    logic                      is_full;
    logic signed [WORD_W-1:0]  front_value;
    logic signed [WORD_W-1:0]  rear_value;
  } out_item_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_RESP = 2'd2
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic exec;   // apply the operation, write the store
    logic rd_en;  // read front and rear words
    logic resp;   // result on the output this cycle
  } ctrl_cmd_t;

endpackage

// ----- hw/rtl/bdeq_ctrl.sv -----
// Controller: sequences accept, store read and result strobe for each transaction.
`timescale 1ns / 1ps

module bdeq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  output bdeq_pkg::ctrl_cmd_t   cmd
);

  bdeq_pkg::state_t state_r;
  bdeq_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdeq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdeq_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = bdeq_pkg::ST_READ;
        end
      end
      bdeq_pkg::ST_READ: begin
        state_nxt = bdeq_pkg::ST_RESP;
      end
      bdeq_pkg::ST_RESP: begin
        state_nxt = bdeq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bdeq_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    busy      = 1'b1;
    cmd.exec  = 1'b0;
    cmd.rd_en = 1'b0;
    cmd.resp  = 1'b0;
    case (state_r)
      bdeq_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.exec = start;
      end
      bdeq_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      bdeq_pkg::ST_RESP: begin
        cmd.resp = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ----- hw/rtl/bdeq_dp.sv -----
// Datapath: circular buffer store, front/rear pointers, entry count and capacity.
`timescale 1ns / 1ps

module bdeq_dp #(
  parameter int DEPTH = bdeq_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bdeq_pkg::ctrl_cmd_t           cmd,
  input  bdeq_pkg::in_item_t            in_data,
  input  logic                          cfg_we,
  input  logic [bdeq_pkg::CAP_W-1:0]    cfg_data,
  output bdeq_pkg::out_item_t           out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = (CW > bdeq_pkg::CAP_W) ? CW : bdeq_pkg::CAP_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [EW-1:0] DEPTH_EXT = EW'(DEPTH);

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] rear_r,  rear_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ok_r,    ok_nxt;
  logic [bdeq_pkg::CAP_W-1:0] cap_r;

  logic signed [bdeq_pkg::WORD_W-1:0] store [DEPTH];
  logic signed [bdeq_pkg::WORD_W-1:0] rd_front_r;
  logic signed [bdeq_pkg::WORD_W-1:0] rd_rear_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] cap_ext;
  logic [EW-1:0] eff_cap;
  logic          full_now;
  logic          empty_now;
  logic          full_out;

  function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
    return (i == LAST_SLOT) ? '0 : AW'(i + AW'(1));
  endfunction

  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST_SLOT : AW'(i - AW'(1));
  endfunction

  // Effective capacity saturates at the store depth
  always_comb begin
    cap_ext   = EW'(cap_r);
    eff_cap   = (cap_ext > DEPTH_EXT) ? DEPTH_EXT : cap_ext;
    full_now  = EW'(count_r) >= eff_cap;
    empty_now = (count_r == '0);
  end

  // Operation decode and pointer update
  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    count_nxt = count_r;
    ok_nxt    = ok_r;
    wr_en     = 1'b0;
    wr_addr   = rear_r;
    if (cmd.exec) begin
      ok_nxt = 1'b0;
      case (in_data.func)
        bdeq_pkg::FUNC_PUSH_FRONT: begin
          if (!full_now) begin
            front_nxt = slot_prev(front_r);
            wr_en     = 1'b1;
            wr_addr   = slot_prev(front_r);
            count_nxt = CW'(count_r + CW'(1));
            ok_nxt    = 1'b1;
          end
        end
        bdeq_pkg::FUNC_PUSH_BACK: begin
          if (!full_now) begin
            rear_nxt  = slot_next(rear_r);
            wr_en     = 1'b1;
            wr_addr   = rear_r;
            count_nxt = CW'(count_r + CW'(1));
            ok_nxt    = 1'b1;
          end
        end
        bdeq_pkg::FUNC_POP_FRONT: begin
          if (!empty_now) begin
            front_nxt = slot_next(front_r);
            count_nxt = CW'(count_r - CW'(1));
            ok_nxt    = 1'b1;
          end
        end
        bdeq_pkg::FUNC_POP_BACK: begin
          if (!empty_now) begin
            rear_nxt  = slot_prev(rear_r);
            count_nxt = CW'(count_r - CW'(1));
            ok_nxt    = 1'b1;
          end
        end
        bdeq_pkg::FUNC_QUERY: begin
          ok_nxt = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end
  end

  // Control registers and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      count_r <= '0;
      ok_r    <= 1'b0;
      cap_r   <= bdeq_pkg::CAP_RESET;
    end else begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      count_r <= count_nxt;
      ok_r    <= ok_nxt;
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

  // Entry store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= in_data.value;
    end
    if (cmd.rd_en) begin
      rd_front_r <= store[front_r];
      rd_rear_r  <= store[slot_prev(rear_r)];
    end
  end

  // Result fields; count is final once the operation has been applied
  assign full_out = full_now;

  always_comb begin
    out_data.ok          = ok_r;
    out_data.is_empty    = empty_now;
    out_data.is_full     = full_out;
    out_data.front_value = empty_now ? bdeq_pkg::EMPTY_WORD : rd_front_r;
    out_data.rear_value  = empty_now ? bdeq_pkg::EMPTY_WORD : rd_rear_r;
  end

endmodule

// ----- hw/rtl/bounded_double_ended_queue.sv -----
// Top level: bounded double-ended queue of signed 32-bit words.
`timescale 1ns / 1ps
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   in_data carries func (push front/back, pop front/back, query) and value.
//   Each transaction gives one result on out_data, shown for exactly one
//   cycle with out_valid high. The receiver cannot stall it.
//   Timing: the accept edge applies the operation and writes the store,
//   state ST_READ then reads the front and rear words from the store, and
//   state ST_RESP presents the result. No new transaction is taken until
//   the result is shown; busy is high in ST_READ and ST_RESP. The three
//   steps are set by the store's registered read port following the write.
//   cfg_data (capacity, 11 bits) is written when cfg_valid and cfg_ready are
//   high; cfg_ready is high while the block is idle.
//   Reset (rst_n low, synchronous) empties the queue and sets the capacity
//   to 1024; store contents are not cleared, and only written entries are
//   ever shown on out_data.
//
module bounded_double_ended_queue #(
  parameter int DEPTH = bdeq_pkg::DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  bdeq_pkg::in_item_t          in_data,
  output logic                        out_valid,
  output bdeq_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bdeq_pkg::CAP_W-1:0]  cfg_data
);

  bdeq_pkg::ctrl_cmd_t cmd;

  bdeq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  bdeq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

  assign out_valid = cmd.resp;
  assign cfg_ready = ~busy;

endmodule
